FILE: rtl/ordered_list_engine_core_assert.svh
// ----------------------------------------------------------------------------
// ordered list engine assertion macros
// concurrent checks clocked on clock and quiet while reset is high
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_ENGINE_CORE_ASSERT_SVH
`define ORDERED_LIST_ENGINE_CORE_ASSERT_SVH

// same-cycle implication
`define OLE_CHECK(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define OLE_CHECK_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/olist_pkg.sv
// ----------------------------------------------------------------------------
// olist_pkg
// shared widths, operation and status codes and sequencer control types
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package olist_pkg;

   localparam int CapacityDefault = 64;
   localparam int MaxResults      = 64;

   localparam int OpWidth    = 3;
   localparam int ValWidth   = 64;
   localparam int PosWidth   = 6;
   localparam int StatWidth  = 2;
   localparam int LenWidth   = 7;
   localparam int IdxWidth   = 6;
   localparam int StepWidth  = 4;

   // operation codes
   localparam logic [OpWidth-1:0] OP_APPEND    = 3'd0;
   localparam logic [OpWidth-1:0] OP_DEL_FIRST = 3'd1;
   localparam logic [OpWidth-1:0] OP_DEL_ALL   = 3'd2;
   localparam logic [OpWidth-1:0] OP_OVERWRITE = 3'd3;
   localparam logic [OpWidth-1:0] OP_DUMP      = 3'd4;

   // status codes
   localparam logic [StatWidth-1:0] ST_DONE     = 2'd0;
   localparam logic [StatWidth-1:0] ST_FULL     = 2'd1;
   localparam logic [StatWidth-1:0] ST_NO_MATCH = 2'd2;
   localparam logic [StatWidth-1:0] ST_RANGE    = 2'd3;

   // jump conditions of the microprogram
   typedef enum logic [3:0] {
      C_NEVER,
      C_ALWAYS,
      C_FULL,
      C_POS_OK,
      C_WALK_END,
      C_EMPTY,
      C_OUT_FREE,
      C_DUMP_END
   } cond_type;

   // one control word
   typedef struct packed {
      cond_type               cond;
      logic [StepWidth-1:0]   target;
      logic                   hold;        // stay on this step when cond is false
      logic                   dispatch;    // jump by operation code when a beat arrives
      logic                   take_req;
      logic                   mem_wr;      // write the request value
      logic                   wa_pos;      // write address is position, else count
      logic                   cnt_inc;
      logic                   stat_ld;
      logic [StatWidth-1:0]   stat;
      logic                   walk;        // compacting pass, one entry a cycle
      logic                   walk_done;
      logic                   set_empty;
      logic                   dump_prime;
      logic                   dump_out;
      logic                   load_stat;
   } ctl_type;

   // datapath conditions seen by the sequencer
   typedef struct packed {
      logic req;
      logic full;
      logic pos_ok;
      logic walk_end;
      logic empty;
      logic out_free;
      logic dump_end;
   } flags_type;

endpackage

FILE: rtl/olist_ram.sv
// ----------------------------------------------------------------------------
// olist_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module olist_ram #(
   parameter int DATA_WIDTH = olist_pkg::ValWidth,
   parameter int DEPTH      = olist_pkg::CapacityDefault
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  logic [DATA_WIDTH-1:0]         wr_data,
   input  logic                          rd_en,
   input  logic [$clog2(DEPTH)-1:0]      rd_addr,
   output logic [DATA_WIDTH-1:0]         rd_data
);

   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/olist_seq.sv
// ----------------------------------------------------------------------------
// olist_seq
// microprogram rom, step counter and jump logic
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module olist_seq (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [olist_pkg::OpWidth-1:0]   op,
   input  olist_pkg::flags_type            flags,
   output olist_pkg::ctl_type              ctl
);

   import olist_pkg::*;

   // step addresses
   localparam logic [StepWidth-1:0] S_IDLE      = 4'd0;
   localparam logic [StepWidth-1:0] S_APP       = 4'd1;
   localparam logic [StepWidth-1:0] S_APP_WR    = 4'd2;
   localparam logic [StepWidth-1:0] S_APP_FULL  = 4'd3;
   localparam logic [StepWidth-1:0] S_OVW       = 4'd4;
   localparam logic [StepWidth-1:0] S_OVW_BAD   = 4'd5;
   localparam logic [StepWidth-1:0] S_OVW_WR    = 4'd6;
   localparam logic [StepWidth-1:0] S_WALK      = 4'd7;
   localparam logic [StepWidth-1:0] S_WALK_END  = 4'd8;
   localparam logic [StepWidth-1:0] S_DMP       = 4'd9;
   localparam logic [StepWidth-1:0] S_DMP_RD    = 4'd10;
   localparam logic [StepWidth-1:0] S_DMP_OUT   = 4'd11;
   localparam logic [StepWidth-1:0] S_DMP_EMPTY = 4'd12;
   localparam logic [StepWidth-1:0] S_RSP       = 4'd13;

   function automatic ctl_type ucode(input logic [StepWidth-1:0] step);
      ctl_type w;
      w = '0;
      unique case (step)
         S_IDLE: begin
            w.take_req = 1'b1;
            w.dispatch = 1'b1;
         end
         S_APP: begin
            w.cond   = C_FULL;
            w.target = S_APP_FULL;
         end
         S_APP_WR: begin
            w.mem_wr  = 1'b1;
            w.cnt_inc = 1'b1;
            w.cond    = C_ALWAYS;
            w.target  = S_RSP;
         end
         S_APP_FULL: begin
            w.stat_ld = 1'b1;
            w.stat    = ST_FULL;
            w.cond    = C_ALWAYS;
            w.target  = S_RSP;
         end
         S_OVW: begin
            w.cond   = C_POS_OK;
            w.target = S_OVW_WR;
         end
         S_OVW_BAD: begin
            w.stat_ld = 1'b1;
            w.stat    = ST_RANGE;
            w.cond    = C_ALWAYS;
            w.target  = S_RSP;
         end
         S_OVW_WR: begin
            w.mem_wr = 1'b1;
            w.wa_pos = 1'b1;
            w.cond   = C_ALWAYS;
            w.target = S_RSP;
         end
         S_WALK: begin
            w.walk   = 1'b1;
            w.cond   = C_WALK_END;
            w.target = S_WALK_END;
            w.hold   = 1'b1;
         end
         S_WALK_END: begin
            w.walk_done = 1'b1;
            w.cond      = C_ALWAYS;
            w.target    = S_RSP;
         end
         S_DMP: begin
            w.cond   = C_EMPTY;
            w.target = S_DMP_EMPTY;
         end
         S_DMP_RD: begin
            w.dump_prime = 1'b1;
         end
         S_DMP_OUT: begin
            w.dump_out = 1'b1;
            w.cond     = C_DUMP_END;
            w.target   = S_IDLE;
            w.hold     = 1'b1;
         end
         S_DMP_EMPTY: begin
            w.set_empty = 1'b1;
         end
         S_RSP: begin
            w.load_stat = 1'b1;
            w.cond      = C_OUT_FREE;
            w.target    = S_IDLE;
            w.hold      = 1'b1;
         end
         default: begin
            w.cond   = C_ALWAYS;
            w.target = S_IDLE;
         end
      endcase
      return w;
   endfunction

   function automatic logic [StepWidth-1:0] entry_step(input logic [OpWidth-1:0] code);
      logic [StepWidth-1:0] s;
      unique case (code)
         OP_APPEND:                s = S_APP;
         OP_DEL_FIRST, OP_DEL_ALL: s = S_WALK;
         OP_OVERWRITE:             s = S_OVW;
         OP_DUMP:                  s = S_DMP;
         default:                  s = S_RSP;
      endcase
      return s;
   endfunction

   logic [StepWidth-1:0] pc_ff;
   logic [StepWidth-1:0] pc_in;
   logic                 cond_true;

   assign ctl = ucode(pc_ff);

   always_comb begin
      unique case (ctl.cond)
         C_NEVER:    cond_true = 1'b0;
         C_ALWAYS:   cond_true = 1'b1;
         C_FULL:     cond_true = flags.full;
         C_POS_OK:   cond_true = flags.pos_ok;
         C_WALK_END: cond_true = flags.walk_end;
         C_EMPTY:    cond_true = flags.empty;
         C_OUT_FREE: cond_true = flags.out_free;
         C_DUMP_END: cond_true = flags.dump_end;
         default:    cond_true = 1'b0;
      endcase

      if (ctl.dispatch) begin
         pc_in = flags.req ? entry_step(op) : pc_ff;
      end else if (cond_true) begin
         pc_in = ctl.target;
      end else if (ctl.hold) begin
         pc_in = pc_ff;
      end else begin
         pc_in = pc_ff + StepWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= S_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

FILE: rtl/ordered_list_engine_core.sv
// ----------------------------------------------------------------------------
// ordered_list_engine_core
// ordered list of 64-bit values in a ram with append, delete, overwrite and dump
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// one request beat is taken at a time and the list lives in a single ram with
// one write and one registered read port, so that port sets the pace: append
// and overwrite go through a check step and then a write step or an error
// step before the result step, unused codes go straight to the result step,
// both delete kinds walk the list once, reading one entry each cycle and
// writing back each kept entry, and after a check step and a read priming step
// a dump gives one beat a cycle while the consumer keeps rsp_ready high (at
// most 64 beats, the last one marked); a result waiting in the output register
// does not stop the next request beat from being taken, and the ram needs no
// clearing after reset since only entries below the count are ever used

module ordered_list_engine_core #(
   parameter int CAPACITY = olist_pkg::CapacityDefault
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [olist_pkg::OpWidth-1:0]         req_operation,
   input  logic signed [olist_pkg::ValWidth-1:0] req_item_value,
   input  logic [olist_pkg::PosWidth-1:0]        req_position,
   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [olist_pkg::StatWidth-1:0]       rsp_status,
   output logic [olist_pkg::LenWidth-1:0]        rsp_list_length,
   output logic signed [olist_pkg::ValWidth-1:0] rsp_entry_value,
   output logic [olist_pkg::IdxWidth-1:0]        rsp_entry_index,
   output logic                                  rsp_list_empty,
   output logic                                  rsp_last
);

   import olist_pkg::*;

   localparam int CntW    = $clog2(CAPACITY + 1);
   localparam int AddrW   = $clog2(CAPACITY);
   localparam int CmpW    = (CntW > PosWidth) ? CntW : PosWidth;
   localparam int DumpMax = (CAPACITY < MaxResults) ? CAPACITY : MaxResults;

   ctl_type   ctl;
   flags_type flags;

   // held request
   logic [OpWidth-1:0]   op_ff;
   logic [ValWidth-1:0]  val_ff;
   logic [PosWidth-1:0]  pos_ff;

   // list state and walk counters
   logic [CntW-1:0]      count_ff,  count_in;
   logic [CntW-1:0]      rd_idx_ff, rd_idx_in;   // next entry to read
   logic [CntW-1:0]      wr_idx_ff, wr_idx_in;   // kept entries, or beats sent in a dump
   logic                 dvalid_ff, dvalid_in;   // ram read data belongs to the walk
   logic                 matched_ff, matched_in;
   logic [StatWidth-1:0] stat_ff,   stat_in;
   logic                 empty_ff,  empty_in;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [StatWidth-1:0] rsp_status_ff;
   logic [LenWidth-1:0]  rsp_length_ff;
   logic signed [ValWidth-1:0] rsp_value_ff;
   logic [IdxWidth-1:0]  rsp_index_ff;
   logic                 rsp_empty_ff;
   logic                 rsp_last_ff;

   // ram ports
   logic                 ram_we;
   logic [AddrW-1:0]     ram_waddr;
   logic [ValWidth-1:0]  ram_wdata;
   logic                 ram_re;
   logic [ValWidth-1:0]  ram_rdata;

   logic                 accept;
   logic                 out_free;
   logic                 walk_rd;
   logic                 keep;
   logic                 walk_wr;
   logic                 load_s;
   logic                 load_e;
   logic [CntW-1:0]      dump_n;
   logic                 dump_final;

   // dispatch looks at the operation of the beat being taken
   olist_seq u_seq (
      .clock (clock),
      .reset (reset),
      .op    (req_operation),
      .flags (flags),
      .ctl   (ctl)
   );

   olist_ram #(
      .DATA_WIDTH (ValWidth),
      .DEPTH      (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (rd_idx_ff[AddrW-1:0]),
      .rd_data (ram_rdata)
   );

   assign req_ready = ctl.take_req;
   assign accept    = req_valid & ctl.take_req;

   // output register is free when empty or being drained this cycle
   assign out_free  = ~rsp_valid_ff | rsp_ready;

   // dumps stop at the result limit
   assign dump_n     = (count_ff > CntW'(DumpMax)) ? CntW'(DumpMax) : count_ff;
   assign dump_final = ((wr_idx_ff + CntW'(1)) == dump_n);

   // compacting walk: read ahead one entry, decide on the one read last cycle
   assign walk_rd = ctl.walk & (rd_idx_ff < count_ff);
   assign keep    = (ram_rdata != val_ff) | ((op_ff == OP_DEL_FIRST) & matched_ff);
   assign walk_wr = ctl.walk & dvalid_ff & keep;

   assign ram_re    = walk_rd | ctl.dump_prime | (ctl.dump_out & out_free);
   assign ram_we    = walk_wr | ctl.mem_wr;
   assign ram_waddr = walk_wr    ? wr_idx_ff[AddrW-1:0] :
                      ctl.wa_pos ? AddrW'(pos_ff)       :
                                   count_ff[AddrW-1:0];
   assign ram_wdata = walk_wr ? ram_rdata : val_ff;

   assign load_s = ctl.load_stat & out_free;
   assign load_e = ctl.dump_out & out_free;

   always_comb begin
      flags.req      = req_valid;
      flags.full     = (count_ff >= CntW'(CAPACITY));
      flags.pos_ok   = (CmpW'(pos_ff) < CmpW'(count_ff));
      flags.walk_end = ~dvalid_ff & ~(rd_idx_ff < count_ff);
      flags.empty    = (count_ff == '0);
      flags.out_free = out_free;
      flags.dump_end = out_free & dump_final;
   end

   always_comb begin
      count_in   = count_ff;
      rd_idx_in  = rd_idx_ff;
      wr_idx_in  = wr_idx_ff;
      dvalid_in  = walk_rd;
      matched_in = matched_ff;
      stat_in    = stat_ff;
      empty_in   = empty_ff;

      if (accept) begin
         rd_idx_in  = '0;
         wr_idx_in  = '0;
         matched_in = 1'b0;
         stat_in    = ST_DONE;
         empty_in   = 1'b0;
      end else begin
         if (ram_re) begin
            rd_idx_in = rd_idx_ff + CntW'(1);
         end
         if (walk_wr | load_e) begin
            wr_idx_in = wr_idx_ff + CntW'(1);
         end
         if (ctl.walk & dvalid_ff & ~keep) begin
            matched_in = 1'b1;
         end
         if (ctl.cnt_inc) begin
            count_in = count_ff + CntW'(1);
         end
         if (ctl.walk_done) begin
            count_in = wr_idx_ff;
            stat_in  = matched_ff ? ST_DONE : ST_NO_MATCH;
         end
         if (ctl.stat_ld) begin
            stat_in = ctl.stat;
         end
         if (ctl.set_empty) begin
            empty_in = 1'b1;
         end
      end

      if (load_s | load_e) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         dvalid_ff    <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         dvalid_ff    <= dvalid_in;
      end
   end

   // request hold and walk registers
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_operation;
         val_ff <= req_item_value;
         pos_ff <= req_position;
      end
      rd_idx_ff  <= rd_idx_in;
      wr_idx_ff  <= wr_idx_in;
      matched_ff <= matched_in;
      stat_ff    <= stat_in;
      empty_ff   <= empty_in;
   end

   // result payload
   always_ff @(posedge clock) begin
      if (load_s) begin
         rsp_status_ff <= stat_ff;
         rsp_length_ff <= LenWidth'(count_ff);
         rsp_value_ff  <= '0;
         rsp_index_ff  <= '0;
         rsp_empty_ff  <= empty_ff;
         rsp_last_ff   <= 1'b1;
      end else if (load_e) begin
         rsp_status_ff <= ST_DONE;
         rsp_length_ff <= LenWidth'(count_ff);
         rsp_value_ff  <= ram_rdata;
         rsp_index_ff  <= IdxWidth'(wr_idx_ff);
         rsp_empty_ff  <= 1'b0;
         rsp_last_ff   <= dump_final;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_list_length = rsp_length_ff;
   assign rsp_entry_value = rsp_value_ff;
   assign rsp_entry_index = rsp_index_ff;
   assign rsp_list_empty  = rsp_empty_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

FILE: rtl/olist_checker.sv
// ----------------------------------------------------------------------------
// olist_checker
// port-level checks on the result channel of the ordered list engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "ordered_list_engine_core_assert.svh"

module olist_checker #(
   parameter int CAPACITY = olist_pkg::CapacityDefault
) (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic [olist_pkg::StatWidth-1:0]       rsp_status,
   input logic [olist_pkg::LenWidth-1:0]        rsp_list_length,
   input logic signed [olist_pkg::ValWidth-1:0] rsp_entry_value,
   input logic [olist_pkg::IdxWidth-1:0]        rsp_entry_index,
   input logic                                  rsp_list_empty,
   input logic                                  rsp_last
);

   import olist_pkg::*;

   // length never goes past the store size
   `OLE_CHECK(a_len_bound, rsp_valid, int'(rsp_list_length) <= CAPACITY, "length past capacity")

   // an empty dump is a single clean beat
   `OLE_CHECK(a_empty_beat, rsp_valid && rsp_list_empty, rsp_last && (rsp_status == ST_DONE) && (rsp_entry_value == '0) && (rsp_entry_index == '0), "bad empty dump beat")

   // only dump beats can be followed by more beats of the same item
   `OLE_CHECK(a_mid_beat, rsp_valid && !rsp_last, (rsp_status == ST_DONE) && !rsp_list_empty, "non-final beat is not a dump entry")

   // dump entries come in index order
   `OLE_CHECK_NEXT(a_dump_order, rsp_valid && rsp_ready && !rsp_last, !rsp_valid || (rsp_entry_index == $past(rsp_entry_index) + 6'd1), "dump index skipped")

   // a stalled result holds
   `OLE_CHECK_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_entry_value) && $stable(rsp_last) && $stable(rsp_status), "stalled result changed")

endmodule

bind ordered_list_engine_core olist_checker #(.CAPACITY(CAPACITY)) u_olist_checker (.*);
